@@ sv/pfa_pkg.sv @@
// Shared types and constants for the page frame allocator.
// No dependencies; used by pfa_ctrl, pfa_datapath and page_frame_allocator.
`default_nettype none

package pfa_pkg;

    localparam int NUM_PAGES_DEF   = 4096;
    localparam int STATUS_BITS_DEF = 16;

    localparam int OP_W     = 2;
    localparam int PAGE_W   = 12;
    localparam int COUNT_W  = 13;
    localparam int CODE_W   = 16;
    localparam int RESULT_W = 2;

    // status word flag bits
    localparam int BIT_PRESENT = 0;
    localparam int BIT_USED    = 1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_FREE  = 2'd1,
        OP_SET   = 2'd2,
        OP_ALLOC = 2'd3
    } op_t;

    typedef enum logic [RESULT_W-1:0] {
        RES_OK      = 2'd0,
        RES_MISSING = 2'd1,
        RES_NOFIT   = 2'd2
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_WRITE,
        ST_FREE_RD,
        ST_FREE_EV,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_CLAIM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic wr_add;
        logic wr_set;
        logic wr_alloc;
        logic skip_missing;
        logic rd;
        logic free_eval;
        logic scan_eval;
        logic nofit;
        logic publish;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic n_zero;
        logic rem_zero;
        logic cur_out;
        logic above_hi;
        logic clear_last;
        logic fit;
        logic at_end;
    } sts_t;

endpackage

`default_nettype wire

@@ sv/pfa_ctrl.sv @@
// Sequencer for the page frame allocator: clear pass, request dispatch,
// per-page loops and response hand-off. Depends on pfa_pkg.
`default_nettype none

module pfa_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    input  wire pfa_pkg::sts_t sts,
    output pfa_pkg::cmd_t      cmd
);

    pfa_pkg::state_t state_reg;
    pfa_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic            out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfa_pkg::ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = pfa_pkg::ST_IDLE;
            end
            pfa_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = pfa_pkg::ST_DISPATCH;
            end
            pfa_pkg::ST_DISPATCH:
            begin
                if (sts.n_zero)
                    state_next = pfa_pkg::ST_FINISH;
                else
                begin
                    case (sts.op)
                        pfa_pkg::OP_ADD:   state_next = pfa_pkg::ST_WRITE;
                        pfa_pkg::OP_SET:   state_next = pfa_pkg::ST_WRITE;
                        pfa_pkg::OP_FREE:  state_next = pfa_pkg::ST_FREE_RD;
                        pfa_pkg::OP_ALLOC: state_next = pfa_pkg::ST_SCAN_RD;
                        default:           state_next = pfa_pkg::ST_FINISH;
                    endcase
                end
            end
            pfa_pkg::ST_WRITE:
            begin
                if (sts.rem_zero || sts.cur_out)
                    state_next = pfa_pkg::ST_FINISH;
            end
            pfa_pkg::ST_FREE_RD:
            begin
                if (sts.rem_zero)
                    state_next = pfa_pkg::ST_FINISH;
                else if (!sts.cur_out)
                    state_next = pfa_pkg::ST_FREE_EV;
            end
            pfa_pkg::ST_FREE_EV:
            begin
                state_next = pfa_pkg::ST_FREE_RD;
            end
            pfa_pkg::ST_SCAN_RD:
            begin
                if (sts.above_hi)
                    state_next = pfa_pkg::ST_FINISH;
                else
                    state_next = pfa_pkg::ST_SCAN_EV;
            end
            pfa_pkg::ST_SCAN_EV:
            begin
                if (sts.fit)
                    state_next = pfa_pkg::ST_CLAIM;
                else
                    state_next = pfa_pkg::ST_SCAN_RD;
            end
            pfa_pkg::ST_CLAIM:
            begin
                if (sts.at_end)
                    state_next = pfa_pkg::ST_FINISH;
            end
            pfa_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = pfa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            pfa_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            pfa_pkg::ST_IDLE:
            begin
                cmd.load = req_valid;
            end
            pfa_pkg::ST_WRITE:
            begin
                if (!(sts.rem_zero || sts.cur_out))
                begin
                    cmd.wr_add = (sts.op == pfa_pkg::OP_ADD);
                    cmd.wr_set = (sts.op != pfa_pkg::OP_ADD);
                end
            end
            pfa_pkg::ST_FREE_RD:
            begin
                if (!sts.rem_zero)
                begin
                    cmd.skip_missing = sts.cur_out;
                    cmd.rd           = !sts.cur_out;
                end
            end
            pfa_pkg::ST_FREE_EV:
            begin
                cmd.free_eval = 1'b1;
            end
            pfa_pkg::ST_SCAN_RD:
            begin
                cmd.nofit = sts.above_hi;
                cmd.rd    = !sts.above_hi;
            end
            pfa_pkg::ST_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
            end
            pfa_pkg::ST_CLAIM:
            begin
                cmd.wr_alloc = 1'b1;
            end
            pfa_pkg::ST_FINISH:
            begin
                cmd.publish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.publish)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    assign req_stall = (state_reg != pfa_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfa_pkg::ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/pfa_datapath.sv @@
// Datapath for the page frame allocator: page status store, page cursor,
// run tracking and response registers. Depends on pfa_pkg.
`default_nettype none

module pfa_datapath
#(
    parameter int NUM_PAGES   = pfa_pkg::NUM_PAGES_DEF,
    parameter int STATUS_BITS = pfa_pkg::STATUS_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [pfa_pkg::OP_W-1:0]      op,
    input  wire logic [pfa_pkg::PAGE_W-1:0]    first_page,
    input  wire logic [pfa_pkg::PAGE_W-1:0]    last_page,
    input  wire logic [pfa_pkg::COUNT_W-1:0]   count,
    input  wire logic [pfa_pkg::CODE_W-1:0]    code,
    output logic      [pfa_pkg::PAGE_W-1:0]    start_page,
    output logic      [pfa_pkg::RESULT_W-1:0]  status,
    input  wire pfa_pkg::cmd_t                 cmd,
    output pfa_pkg::sts_t                      sts
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = ((PW > pfa_pkg::COUNT_W) ? PW : pfa_pkg::COUNT_W) + 1;
    localparam int SB = STATUS_BITS;
    localparam int NW = pfa_pkg::COUNT_W;

    localparam logic [CW-1:0] LIMIT = CW'(NUM_PAGES);
    localparam logic [CW-1:0] TOP   = CW'(NUM_PAGES - 1);
    localparam logic [SB-1:0] W_PRESENT = SB'(1) << pfa_pkg::BIT_PRESENT;
    localparam logic [SB-1:0] W_USED    = SB'(1) << pfa_pkg::BIT_USED;
    localparam logic [SB-1:0] W_FLAGS   = W_PRESENT | W_USED;

    logic [SB-1:0] mem [NUM_PAGES];

    pfa_pkg::op_t                  op_reg,         op_next;
    logic [NW-1:0]                 n_reg,          n_next;
    logic [NW-1:0]                 rem_reg,        rem_next;
    logic [NW-1:0]                 run_reg,        run_next;
    logic [SB-1:0]                 word_reg,       word_next;
    logic [CW-1:0]                 cur_reg,        cur_next;
    logic [CW-1:0]                 hi_reg,         hi_next;
    logic [CW-1:0]                 end_reg,        end_next;
    logic [PW-1:0]                 origin_reg,     origin_next;
    logic [pfa_pkg::PAGE_W-1:0]    res_start_reg,  res_start_next;
    logic [pfa_pkg::RESULT_W-1:0]  res_status_reg, res_status_next;
    logic [pfa_pkg::PAGE_W-1:0]    out_start_reg,  out_start_next;
    logic [pfa_pkg::RESULT_W-1:0]  out_status_reg, out_status_next;
    logic [SB-1:0]                 rd_reg;

    logic [PW-1:0]  addr;
    logic [31:0]    code_ext;
    logic [SB-1:0]  code_w;
    logic [CW-1:0]  first_w;
    logic [CW-1:0]  last_w;
    logic [NW-1:0]  run_inc;
    logic [PW-1:0]  run_origin;
    logic [CW-1:0]  origin_w;
    logic           rd_present;
    logic           rd_free;
    logic           fit_now;
    logic           we;
    logic [SB-1:0]  wd;

    assign addr       = cur_reg[PW-1:0];
    assign code_ext   = {16'd0, code};
    assign code_w     = code_ext[SB-1:0];
    assign first_w    = CW'(first_page);
    assign last_w     = CW'(last_page);
    assign rd_present = rd_reg[pfa_pkg::BIT_PRESENT];
    assign rd_free    = rd_present && !rd_reg[pfa_pkg::BIT_USED];
    assign run_inc    = run_reg + NW'(1);
    assign fit_now    = rd_free && (run_inc >= n_reg);
    assign run_origin = (run_reg == '0) ? addr : origin_reg;
    assign origin_w   = CW'(run_origin);

    always_comb
    begin
        we = 1'b0;
        wd = '0;
        if (cmd.clear_step)
        begin
            we = 1'b1;
            wd = '0;
        end
        else if (cmd.wr_add)
        begin
            we = (cur_reg != '0);
            wd = W_PRESENT;
        end
        else if (cmd.wr_set)
        begin
            we = 1'b1;
            wd = word_reg;
        end
        else if (cmd.wr_alloc)
        begin
            we = 1'b1;
            wd = word_reg | W_FLAGS;
        end
        else if (cmd.free_eval)
        begin
            we = rd_present;
            wd = W_PRESENT;
        end
    end

    always_comb
    begin
        op_next         = op_reg;
        n_next          = n_reg;
        rem_next        = rem_reg;
        run_next        = run_reg;
        word_next       = word_reg;
        cur_next        = cur_reg;
        hi_next         = hi_reg;
        end_next        = end_reg;
        origin_next     = origin_reg;
        res_start_next  = res_start_reg;
        res_status_next = res_status_reg;
        out_start_next  = out_start_reg;
        out_status_next = out_status_reg;

        if (cmd.load)
        begin
            op_next         = pfa_pkg::op_t'(op);
            n_next          = count;
            rem_next        = count;
            run_next        = '0;
            res_start_next  = '0;
            res_status_next = pfa_pkg::RES_OK;
            hi_next         = (last_w > TOP) ? TOP : last_w;
            if (pfa_pkg::op_t'(op) == pfa_pkg::OP_ALLOC)
            begin
                word_next = code_w & ~W_FLAGS;
                cur_next  = (first_w == '0) ? CW'(1) : first_w;
            end
            else
            begin
                word_next = code_w;
                cur_next  = first_w;
            end
        end

        if (cmd.clear_step || cmd.wr_alloc)
            cur_next = cur_reg + CW'(1);

        if (cmd.wr_add || cmd.wr_set)
        begin
            cur_next = cur_reg + CW'(1);
            rem_next = rem_reg - NW'(1);
        end

        if (cmd.skip_missing || cmd.free_eval)
        begin
            cur_next = cur_reg + CW'(1);
            rem_next = rem_reg - NW'(1);
            if (cmd.skip_missing || !rd_present)
                res_status_next = pfa_pkg::RES_MISSING;
        end

        if (cmd.scan_eval)
        begin
            if (fit_now)
            begin
                res_start_next = origin_w[pfa_pkg::PAGE_W-1:0];
                end_next       = cur_reg;
                cur_next       = origin_w;
            end
            else if (rd_free)
            begin
                run_next    = run_inc;
                origin_next = run_origin;
                cur_next    = cur_reg + CW'(1);
            end
            else
            begin
                run_next = '0;
                cur_next = cur_reg + CW'(1);
            end
        end

        if (cmd.nofit)
            res_status_next = pfa_pkg::RES_NOFIT;

        if (cmd.publish)
        begin
            out_start_next  = res_start_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wd;
        if (cmd.rd)
            rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else
            cur_reg <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        n_reg          <= n_next;
        rem_reg        <= rem_next;
        run_reg        <= run_next;
        word_reg       <= word_next;
        hi_reg         <= hi_next;
        end_reg        <= end_next;
        origin_reg     <= origin_next;
        res_start_reg  <= res_start_next;
        res_status_reg <= res_status_next;
        out_start_reg  <= out_start_next;
        out_status_reg <= out_status_next;
    end

    assign sts.op         = op_reg;
    assign sts.n_zero     = (n_reg == '0);
    assign sts.rem_zero   = (rem_reg == '0);
    assign sts.cur_out    = (cur_reg >= LIMIT);
    assign sts.above_hi   = (cur_reg > hi_reg);
    assign sts.clear_last = (cur_reg == TOP);
    assign sts.fit        = fit_now;
    assign sts.at_end     = (cur_reg == end_reg);

    assign start_page = out_start_reg;
    assign status     = out_status_reg;

endmodule

`default_nettype wire

@@ sv/page_frame_allocator.sv @@
// Page frame allocator top level: sequencer plus datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
//
// Usage:
//   Request channel (req_valid/req_stall): op, first_page, last_page, count,
//   code. A request is taken when req_valid is high and req_stall low.
//   Response channel (rsp_valid/rsp_stall): start_page, status, one response
//   per request, in order.
//   After reset the status store is cleared one page a cycle, with
//   req_stall high; every page then reads as not present.
//   Work per request: a count of zero goes straight to the response;
//   add / set write one page at a time and stop early at the end of the
//   store; free reads each page and writes back each present one;
//   allocate reads and tests page by page until a run fits or the range
//   ends, then claims that run. The status store has a single port.
//   One request is worked on at a time; the next is taken as soon as the
//   previous one has moved into the response register. If the receiver
//   holds rsp_stall, the response holds, and a finished request after it
//   waits until the response register is free.
`default_nettype none

module page_frame_allocator
#(
    parameter int NUM_PAGES   = pfa_pkg::NUM_PAGES_DEF,
    parameter int STATUS_BITS = pfa_pkg::STATUS_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [pfa_pkg::OP_W-1:0]      op,
    input  wire logic [pfa_pkg::PAGE_W-1:0]    first_page,
    input  wire logic [pfa_pkg::PAGE_W-1:0]    last_page,
    input  wire logic [pfa_pkg::COUNT_W-1:0]   count,
    input  wire logic [pfa_pkg::CODE_W-1:0]    code,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output logic      [pfa_pkg::PAGE_W-1:0]    start_page,
    output logic      [pfa_pkg::RESULT_W-1:0]  status
);

    pfa_pkg::cmd_t cmd;
    pfa_pkg::sts_t sts;

    pfa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfa_datapath
    #(
        .NUM_PAGES   (NUM_PAGES),
        .STATUS_BITS (STATUS_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .first_page (first_page),
        .last_page  (last_page),
        .count      (count),
        .code       (code),
        .start_page (start_page),
        .status     (status),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for page_frame_allocator: directed and random requests
// are checked against a behavioural page store kept in the bench.
// Depends on pfa_pkg and the page_frame_allocator RTL.
`timescale 1ns / 100ps

module tb_top;

    import pfa_pkg::*;

    localparam int          NUM_PAGES    = NUM_PAGES_DEF;
    localparam logic [15:0] WORD_FREE    = 16'(1 << BIT_PRESENT);
    localparam logic [15:0] FLAG_MASK    = 16'((1 << BIT_PRESENT) | (1 << BIT_USED));
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_ITEMS = 16;

    typedef struct {
        logic [PAGE_W-1:0] page;
        result_t           res;
    } frame_result_t;

    typedef struct {
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] len;
    } claimed_run_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 req_valid  = 1'b0;
    logic                 req_stall;
    logic [OP_W-1:0]      op         = '0;
    logic [PAGE_W-1:0]    first_page = '0;
    logic [PAGE_W-1:0]    last_page  = '0;
    logic [COUNT_W-1:0]   count      = '0;
    logic [CODE_W-1:0]    code       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall  = 1'b0;
    logic [PAGE_W-1:0]    start_page;
    logic [RESULT_W-1:0]  status;

    logic [15:0]   page_word [NUM_PAGES];
    frame_result_t expected_frames[$];
    claimed_run_t  claimed_runs[$];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int n_requests    = 0;
    int n_placed      = 0;
    int n_nofit       = 0;
    int n_missing     = 0;

    page_frame_allocator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .op         (op),
        .first_page (first_page),
        .last_page  (last_page),
        .count      (count),
        .code       (code),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .start_page (start_page),
        .status     (status)
    );

    always #1 clk = ~clk;

    function automatic frame_result_t predict_frame_result(
        input op_t o, input logic [PAGE_W-1:0] f, input logic [PAGE_W-1:0] l,
        input logic [COUNT_W-1:0] n, input logic [CODE_W-1:0] c);
        frame_result_t r;
        int            lo;
        int            hi;
        int            run;
        int            origin;
        int            p;
        logic          found;
        logic [15:0]   tag;
        r.page = '0;
        r.res  = RES_OK;
        if (n == 0)
            return r;
        case (o)
            OP_ADD:
                for (int i = 0; i < n && f + i < NUM_PAGES; i++)
                    if (f + i != 0)
                        page_word[f + i] = WORD_FREE;
            OP_FREE:
                for (int i = 0; i < n; i++)
                begin
                    p = f + i;
                    if (p >= NUM_PAGES || !page_word[p][BIT_PRESENT])
                        r.res = RES_MISSING;
                    else
                        page_word[p] = WORD_FREE;
                end
            OP_SET:
                for (int i = 0; i < n && f + i < NUM_PAGES; i++)
                    page_word[f + i] = c;
            default:
            begin
                // first fit; page zero never searched
                tag    = c & ~FLAG_MASK;
                lo     = (f == 0) ? 1 : f;
                hi     = (l > NUM_PAGES - 1) ? NUM_PAGES - 1 : l;
                run    = 0;
                origin = 0;
                found  = 1'b0;
                r.res  = RES_NOFIT;
                for (p = lo; p <= hi && !found; p++)
                begin
                    if (page_word[p][BIT_PRESENT] && !page_word[p][BIT_USED])
                    begin
                        if (run == 0)
                            origin = p;
                        run++;
                        if (run >= n)
                        begin
                            for (int q = origin; q <= p; q++)
                                page_word[q] = FLAG_MASK | tag;
                            r.page = PAGE_W'(origin);
                            r.res  = RES_OK;
                            found  = 1'b1;
                        end
                    end
                    else
                        run = 0;
                end
            end
        endcase
        return r;
    endfunction

    // call at a falling edge; returns at a falling edge
    task automatic issue_request(input op_t o, input logic [PAGE_W-1:0] f,
        input logic [PAGE_W-1:0] l, input logic [COUNT_W-1:0] n,
        input logic [CODE_W-1:0] c);
        frame_result_t r;
        claimed_run_t  cr;
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        op         <= o;
        first_page <= f;
        last_page  <= l;
        count      <= n;
        code       <= c;
        do
            @(posedge clk);
        while (req_stall);
        r = predict_frame_result(o, f, l, n, c);
        expected_frames.push_back(r);
        n_requests++;
        if (o == OP_ALLOC && n != 0 && r.res == RES_OK)
        begin
            cr.page = r.page;
            cr.len  = n;
            claimed_runs.push_back(cr);
            if (claimed_runs.size() > 32)
                void'(claimed_runs.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        frame_result_t e;
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected response start_page %0d status %0d",
                         $time, start_page, status);
                errors++;
            end
            else
            begin
                e = expected_frames.pop_front();
                if (start_page !== e.page)
                begin
                    $display("%0t: start_page expected %0d actual %0d",
                             $time, e.page, start_page);
                    errors++;
                end
                if (status !== e.res)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.res, status);
                    errors++;
                end
                case (e.res)
                    RES_NOFIT:   n_nofit++;
                    RES_MISSING: n_missing++;
                    default:     if (e.page != 0) n_placed++;
                endcase
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(1, 100) <= rsp_stall_pct);
    end

    task automatic test_directed();
        issue_request(OP_ADD,   12'd5,    12'd9,    13'd0,    16'h1234);
        issue_request(OP_FREE,  12'd0,    12'd0,    13'd0,    16'h0000);
        issue_request(OP_SET,   12'd4095, 12'd4095, 13'd0,    16'hFFFF);
        issue_request(OP_ALLOC, 12'd1,    12'd4095, 13'd0,    16'h00F0);
        issue_request(OP_FREE,  12'd1,    12'd1,    13'd1,    16'h0000);
        issue_request(OP_ALLOC, 12'd0,    12'd4095, 13'd1,    16'h0000);
        issue_request(OP_ADD,   12'd0,    12'd0,    13'd4096, 16'h0000);
        issue_request(OP_ALLOC, 12'd0,    12'd4095, 13'd1,    16'hFFFF);
        issue_request(OP_ALLOC, 12'd4000, 12'd4095, 13'd200,  16'h0010);
        issue_request(OP_ALLOC, 12'd10,   12'd5,    13'd1,    16'h0010);
        issue_request(OP_SET,   12'd20,   12'd0,    13'd3,    16'h0000);
        issue_request(OP_ALLOC, 12'd16,   12'd40,   13'd5,    16'hA5A4);
        issue_request(OP_SET,   12'd4090, 12'd0,    13'd100,  16'hFFFF);
        issue_request(OP_FREE,  12'd4090, 12'd0,    13'd10,   16'h0000);
        issue_request(OP_FREE,  12'd0,    12'd0,    13'd3,    16'h0000);
        issue_request(OP_ALLOC, 12'd4095, 12'd4095, 13'd1,    16'h5554);
        issue_request(OP_ADD,   12'd4095, 12'd0,    13'd4096, 16'h0000);
        issue_request(OP_SET,   12'd0,    12'd0,    13'd1,    16'h0001);
        issue_request(OP_ALLOC, 12'd0,    12'd2,    13'd2,    16'h0000);
        issue_request(OP_FREE,  12'd0,    12'd0,    13'd4096, 16'h0000);
        issue_request(OP_ALLOC, 12'd1,    12'd4095, 13'd4096, 16'h0000);
        issue_request(OP_ADD,   12'd1,    12'd0,    13'd4095, 16'h0000);
        issue_request(OP_ALLOC, 12'd1,    12'd4095, 13'd4095, 16'hFFFC);
        issue_request(OP_FREE,  12'd1,    12'd0,    13'd4095, 16'h0000);
        wait_idle();
    endtask

    task automatic run_random(input int items);
        int                 sel;
        op_t                o;
        logic [PAGE_W-1:0]  f;
        logic [PAGE_W-1:0]  l;
        logic [COUNT_W-1:0] n;
        logic [CODE_W-1:0]  c;
        claimed_run_t       cr;
        for (int k = 0; k < items; k++)
        begin
            sel = $urandom_range(0, 99);
            o   = (sel < 15) ? OP_ADD : (sel < 40) ? OP_FREE :
                  (sel < 50) ? OP_SET : OP_ALLOC;
            f   = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
            sel = $urandom_range(0, 99);
            n   = (sel < 5) ? 13'd0 : (sel < 15) ? 13'($urandom_range(1, 4096)) :
                  13'($urandom_range(1, 8));
            c   = CODE_W'($urandom_range(0, 65535));
            l   = (o == OP_ALLOC && $urandom_range(0, 9) == 0) ?
                  12'($urandom_range(0, NUM_PAGES - 1)) : f + 12'($urandom_range(0, 60));
            // hand back a run claimed earlier
            if (o == OP_FREE && claimed_runs.size() != 0 && $urandom_range(0, 1))
            begin
                cr = claimed_runs.pop_front();
                f  = cr.page;
                n  = cr.len;
            end
            issue_request(o, f, l, n, c);
        end
        wait_idle();
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        rsp_stall_pct <= 0;
        run_random(RANDOM_ITEMS);
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 81;
        rsp_stall_pct <= 0;
        run_random(RANDOM_ITEMS);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        rsp_stall_pct <= 81;
        run_random(RANDOM_ITEMS);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 35;
        rsp_stall_pct <= 35;
        run_random(RANDOM_ITEMS);
    endtask

    // long receiver hold-off while short requests keep coming
    task automatic test_backpressure();
        logic [PAGE_W-1:0] f;
        send_idle_pct = 0;
        rsp_stall_pct <= 0;
        hold_token <= hold_token + 1;
        for (int k = 0; k < 12; k++)
        begin
            f = 12'($urandom_range(1, 4000));
            issue_request(op_t'($urandom_range(0, 3)), f, f + 12'($urandom_range(0, 8)),
                          13'($urandom_range(1, 4)), 16'($urandom_range(0, 65535)));
        end
        wait_idle();
    endtask

    initial
    begin
        for (int p = 0; p < NUM_PAGES; p++)
            page_word[p] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        $display("Covered %0d requests over idle, stall and hold-off phases:", n_requests);
        $display("  %0d runs placed, %0d without a fit, %0d frees of missing pages",
                 n_placed, n_nofit, n_missing);
        if (errors == 0)
            $display("[page_frame_allocator] OK");
        else
            $display("[page_frame_allocator] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[page_frame_allocator] ERROR");
        $finish;
    end

endmodule

@@ page_frame_allocator.f @@
sv/pfa_pkg.sv
sv/pfa_ctrl.sv
sv/pfa_datapath.sv
sv/page_frame_allocator.sv
bench/tb_top.sv
